FILE: rtl/dtdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_pkg: shared types and constants
// Job record between parser and day counter, calendar constants and tables.
// ----------------------------------------------------------------------------
package dtdn_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [13:0] FIRST_YEAR    = 14'd1752;
    localparam logic [6:0]  MAX_MONTH     = 7'd12;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    // leap years in 1..1751
    localparam logic [21:0] LEAPS_BEFORE  = 22'd424;
    // ceil(2^16 / 25): exact quotient for dividends below 2500
    localparam logic [11:0] RECIP_25      = 12'd2622;

    typedef struct packed {
        logic        ok;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [13:0] year;
    } t_job;

    // days in the whole months before the given month (non-leap year)
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dtdn_char_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_char_if: character channel
// Valid/ready channel carrying one ASCII character and an end-of-text flag.
// ----------------------------------------------------------------------------
interface dtdn_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/dtdn_day_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_day_if: result channel
// Valid/ready channel carrying a day number and a status bit.
// ----------------------------------------------------------------------------
interface dtdn_day_if;
    logic        valid;
    logic        ready;
    logic [21:0] day_number;
    logic        status;

    modport source (output valid, output day_number, output status, input ready);
    modport sink   (input valid, input day_number, input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/dtdn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_front: date text parser
// Takes one character per cycle while the queue is not full, gathers month,
// day and year digits and pushes a checked job into the queue on the last character.
// ----------------------------------------------------------------------------
module dtdn_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dtdn_char_if.sink           i_char,
    input  wire logic           i_full,
    output logic                o_push,
    output dtdn_pkg::t_job      o_job
);

    typedef enum logic [1:0] {
        PH_MONTH = 2'd0,
        PH_DAY   = 2'd1,
        PH_YEAR  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic [13:0] r_year, n_year;

    logic       is_digit;
    logic       is_slash;
    logic [3:0] dig;
    logic       accept;

    assign i_char.ready = !i_full;
    assign accept       = i_char.valid && i_char.ready;

    always_comb begin
        is_digit = (i_char.char_code >= CHAR_ZERO) && (i_char.char_code <= CHAR_NINE);
        is_slash = (i_char.char_code == CHAR_SLASH);
        dig      = is_digit ? 4'(i_char.char_code - CHAR_ZERO) : 4'd0;

        n_phase = r_phase;
        n_count = r_count;
        n_month = r_month;
        n_day   = r_day;
        n_year  = r_year;

        unique case (r_phase)
            PH_MONTH: begin
                if (is_digit && r_count < 3'd2) begin
                    n_month = 7'(r_month * 7'd10 + {3'b0, dig});
                    n_count = r_count + 3'd1;
                end else if (is_slash) begin
                    n_phase = PH_DAY;
                    n_count = 3'd0;
                end else if (is_digit) begin
                    // third digit opens the day field
                    n_phase = PH_DAY;
                    n_day   = {3'b0, dig};
                    n_count = 3'd1;
                end else begin
                    n_phase = PH_DONE;
                    n_count = 3'd0;
                end
            end
            PH_DAY: begin
                if (is_digit && r_count < 3'd2) begin
                    n_day   = 7'(r_day * 7'd10 + {3'b0, dig});
                    n_count = r_count + 3'd1;
                end else if (is_slash) begin
                    n_phase = PH_YEAR;
                    n_count = 3'd0;
                end else if (is_digit) begin
                    // year is still zero here
                    n_phase = PH_YEAR;
                    n_year  = {10'b0, dig};
                    n_count = 3'd1;
                end else begin
                    n_phase = PH_DONE;
                    n_count = 3'd0;
                end
            end
            PH_YEAR: begin
                if (is_digit) begin
                    n_year  = 14'(r_year * 14'd10 + {10'b0, dig});
                    n_count = r_count + 3'd1;
                    if (r_count == 3'd3) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_phase = PH_DONE;
                    n_count = 3'd0;
                end
            end
            PH_DONE: begin
                // trailing characters ignored
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_comb begin
        o_push      = accept && i_char.last_char;
        o_job.ok    = (n_phase == PH_DONE) && (n_count == 3'd4) &&
                      (n_year >= dtdn_pkg::FIRST_YEAR) && (n_month <= dtdn_pkg::MAX_MONTH);
        o_job.month = n_month;
        o_job.day   = n_day;
        o_job.year  = n_year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MONTH;
            r_count <= 3'd0;
            r_month <= 7'd0;
            r_day   <= 7'd0;
            r_year  <= 14'd0;
        end else if (accept) begin
            if (i_char.last_char) begin
                r_phase <= PH_MONTH;
                r_count <= 3'd0;
                r_month <= 7'd0;
                r_day   <= 7'd0;
                r_year  <= 14'd0;
            end else begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_month <= n_month;
                r_day   <= n_day;
                r_year  <= n_year;
            end
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char.last_char) |=> (r_phase == PH_MONTH && r_count == 3'd0))
        else $error("parser did not restart after end of text");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_count == 3'd4 || r_count == 3'd0))
        else $error("done phase with partial digit count");

endmodule
`default_nettype wire

FILE: rtl/dtdn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_queue: job queue
// Small register FIFO between parser and day counter.
// ----------------------------------------------------------------------------
module dtdn_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dtdn_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dtdn_pkg::t_job      o_job
);

    dtdn_pkg::t_job                r_mem [dtdn_pkg::QUEUE_DEPTH];
    logic [dtdn_pkg::QPTR_W-1:0]   r_wptr;
    logic [dtdn_pkg::QPTR_W-1:0]   r_rptr;
    logic [dtdn_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == dtdn_pkg::QCNT_W'(dtdn_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dtdn_pkg::QCNT_W'(dtdn_pkg::QUEUE_DEPTH))
        else $error("job queue occupancy out of range");

endmodule
`default_nettype wire

FILE: rtl/dtdn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtdn_back: day counter
// Three-stage pipeline: constant multiplies, leap counts, final sum into the
// output register. All stages advance together when the output can move.
// ----------------------------------------------------------------------------
module dtdn_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire dtdn_pkg::t_job i_job,
    output logic                o_pop,
    dtdn_day_if.source          o_day
);

    logic en;

    // stage 1 inputs
    logic [13:0] ym1;
    logic [11:0] q0, q1;
    logic [23:0] p0, p1;
    logic [13:0] yoff;
    logic [21:0] yd;
    logic [8:0]  base;

    // stage 1 registers
    logic        r_v1, r1_ok, r1_gt2;
    logic [8:0]  r1_base;
    logic [21:0] r1_yd;
    logic [11:0] r1_q0, r1_q1;
    logic [7:0]  r1_c0, r1_c1;

    // stage 2
    logic [11:0] l0, l1;
    logic        leap;
    logic        r_v2, r2_ok;
    logic [21:0] r2_sum;
    logic [11:0] r2_l1;

    // output stage
    logic        r_v3, r_status;
    logic [21:0] r_day;

    assign en    = !r_v3 || o_day.ready;
    assign o_pop = en && i_valid;

    always_comb begin
        ym1  = i_job.year - 14'd1;
        q0   = i_job.year[13:2];
        q1   = ym1[13:2];
        // floor(q/25) = floor(y/100)
        p0   = 24'(q0) * 24'(dtdn_pkg::RECIP_25);
        p1   = 24'(q1) * 24'(dtdn_pkg::RECIP_25);
        yoff = i_job.year - dtdn_pkg::FIRST_YEAR;
        yd   = 22'(yoff) * 22'(dtdn_pkg::DAYS_PER_YEAR);
        base = 9'({2'b0, i_job.day} + dtdn_pkg::cum_days(i_job.month[3:0]));
    end

    always_comb begin
        // leaps in 1..n = n/4 - n/100 + n/400
        l0   = r1_q0 - 12'(r1_c0) + 12'(r1_c0[7:2]);
        l1   = r1_q1 - 12'(r1_c1) + 12'(r1_c1[7:2]);
        leap = (l0 != l1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok   <= i_job.ok;
            r1_gt2  <= (i_job.month > 7'd2);
            r1_base <= base;
            r1_yd   <= yd;
            r1_q0   <= q0;
            r1_q1   <= q1;
            r1_c0   <= p0[23:16];
            r1_c1   <= p1[23:16];

            r2_ok   <= r1_ok;
            r2_sum  <= r1_yd + 22'(r1_base) + 22'(r1_gt2 && leap);
            r2_l1   <= l1;

            r_status <= !r2_ok;
            r_day    <= r2_ok ? 22'(r2_sum + 22'(r2_l1) - dtdn_pkg::LEAPS_BEFORE) : 22'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_day.valid      = r_v3;
    assign o_day.day_number = r_day;
    assign o_day.status     = r_status;

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_status) |-> (r_day == 22'd0))
        else $error("invalid result carries a nonzero day number");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v1)
        else $error("popped job did not enter the pipeline");

endmodule
`default_nettype wire

FILE: rtl/date_text_to_day_number.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_text_to_day_number: MMDDYYYY text to days since 31 Dec 1751
// i_char takes one ASCII character per transaction; last_char marks the end
// of a date text. For every text o_day returns one transaction: day_number
// and status 0 for a valid date, or day_number 0 and status 1 when the year
// is short, before 1752, the month is above 12 or a stray character occurs.
// Slashes after month and day are optional; characters after the year are
// ignored.
// Throughput: one character per cycle, back to back; i_char.ready is low
// only while the four-entry job queue is full.
// A result passes the parser push into the job queue, then a three-stage
// day-count pipeline whose multiplies and leap counts set the depth.
// When o_day.ready is low the pipeline holds its result; the queue then
// absorbs up to four more texts before i_char.ready drops.
// Reset (synchronous, active low) returns the parser to the month field and
// empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module date_text_to_day_number (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dtdn_char_if.sink   i_char,
    dtdn_day_if.source  o_day
);

    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;
    dtdn_pkg::t_job  push_job;
    dtdn_pkg::t_job  head_job;

    dtdn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    dtdn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    dtdn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_day   (o_day)
    );

endmodule
`default_nettype wire

FILE: tb/tb_date_text_to_day_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_text_to_day_number: self-checking testbench
// Sends MMDDYYYY date texts one character per transaction: a short directed
// table first, then random well-formed, broken and noise texts. Sender and
// receiver idle at random. An in-bench date parser and day counter predicts each
// result not fixed by a directed row; the output is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_date_text_to_day_number;

    localparam int          RESET_CYCLES = 11;
    localparam int          RAND_ITEMS   = 890;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          HOLD_AFTER   = 300;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          N_DIR        = 10;
    localparam int unsigned EPOCH_YEAR   = 1752;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam logic [7:0]  CH_SLASH     = 8'h2F;
    // '#' in a directed text stands for a NUL character on the bus
    localparam logic [7:0]  CH_NUL_MARK  = 8'h23;

    localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef enum logic [1:0] {FLD_MONTH, FLD_DAY, FLD_YEAR, FLD_DONE} t_field;
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_COMB, RX_HEAVY} t_rx_mode;

    typedef struct packed {
        logic [21:0] day_number;
        logic        status;
    } t_day_res;

    typedef struct {
        t_field      fld;
        int unsigned ndig;
        int unsigned month;
        int unsigned day;
        int unsigned year;
    } t_date_parse;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
        bit         typed;
        t_day_res   res;
    } t_char_item;

    typedef struct {
        string       text;
        bit          typed;
        logic [21:0] day;
        logic        status;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    dtdn_char_if char_if ();
    dtdn_day_if  day_if ();

    date_text_to_day_number u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_day   (day_if)
    );

    t_date_parse  date_st = '{FLD_MONTH, 0, 0, 0, 0};
    t_char_item   char_stim [$];
    t_day_res     pending_days [$];
    byte unsigned date_txt [$];
    int           chars_taken    = 0;
    int           chars_checked  = 0;
    int           idle_cycles    = 0;
    int           mismatch_count = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------- prediction ----------------

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned leaps_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic void add_year_digit(input int unsigned d);
        date_st.year = date_st.year * 10 + d;
        date_st.ndig++;
        if (date_st.ndig >= 4) date_st.fld = FLD_DONE;
    endfunction

    // Advances the parse by one character; returns 1 with the day count when
    // the character closes a text.
    function automatic bit parse_date_char(input logic [7:0] c, input logic is_last,
                                           output t_day_res res);
        bit          is_dig;
        bit          is_slash;
        int unsigned d;
        int unsigned days;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = is_dig ? int'(c - CH_ZERO) : 0;
        is_slash = (c == CH_SLASH);
        res      = '{day_number: 22'd0, status: 1'b1};
        case (date_st.fld)
            FLD_MONTH: begin
                if (is_dig && date_st.ndig < 2) begin
                    date_st.month = date_st.month * 10 + d;
                    date_st.ndig++;
                end else if (is_slash) begin
                    date_st.fld  = FLD_DAY;
                    date_st.ndig = 0;
                end else if (is_dig) begin
                    // third digit opens the day field
                    date_st.fld  = FLD_DAY;
                    date_st.day  = d;
                    date_st.ndig = 1;
                end else begin
                    date_st.fld  = FLD_DONE;
                    date_st.ndig = 0;
                end
            end
            FLD_DAY: begin
                if (is_dig && date_st.ndig < 2) begin
                    date_st.day = date_st.day * 10 + d;
                    date_st.ndig++;
                end else if (is_slash) begin
                    date_st.fld  = FLD_YEAR;
                    date_st.ndig = 0;
                end else if (is_dig) begin
                    date_st.fld  = FLD_YEAR;
                    date_st.ndig = 0;
                    add_year_digit(d);
                end else begin
                    date_st.fld  = FLD_DONE;
                    date_st.ndig = 0;
                end
            end
            FLD_YEAR: begin
                if (is_dig) begin
                    add_year_digit(d);
                end else begin
                    date_st.fld  = FLD_DONE;
                    date_st.ndig = 0;
                end
            end
            default: ;
        endcase
        if (!is_last) return 1'b0;
        if (date_st.fld == FLD_DONE && date_st.ndig == 4 &&
            date_st.year >= EPOCH_YEAR && date_st.month <= 12) begin
            days = date_st.day;
            for (int m = 1; m < date_st.month; m++) days += MONTH_LEN[m];
            if (date_st.month > 2 && is_leap_year(date_st.year)) days++;
            days += 365 * (date_st.year - EPOCH_YEAR);
            days += leaps_through(date_st.year - 1) - leaps_through(EPOCH_YEAR - 1);
            res = '{day_number: days[21:0], status: 1'b0};
        end
        date_st = '{FLD_MONTH, 0, 0, 0, 0};
        return 1'b1;
    endfunction

    // month or day: two digits with an optional slash, or one digit and a slash
    function automatic void put_date_field(input int unsigned v);
        if (v < 10 && $urandom_range(0, 1) == 1) begin
            date_txt.push_back(8'(CH_ZERO + v));
            date_txt.push_back(CH_SLASH);
        end else begin
            date_txt.push_back(8'(CH_ZERO + v / 10));
            date_txt.push_back(8'(CH_ZERO + v % 10));
            if ($urandom_range(0, 1) == 1) date_txt.push_back(CH_SLASH);
        end
    endfunction

    // ---------------- checking, prediction and watchdog ----------------

    always @(posedge i_clk) begin : check_days
        t_day_res want;
        t_day_res pred;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (day_if.valid && day_if.ready) begin
                moved = 1'b1;
                if (pending_days.size() == 0) begin
                    $error("result with nothing expected: day_number %0d status %0d",
                           day_if.day_number, day_if.status);
                    mismatch_count++;
                end else begin
                    want = pending_days.pop_front();
                    if (day_if.day_number !== want.day_number) begin
                        $error("day_number: expected %0d, got %0d",
                               want.day_number, day_if.day_number);
                        mismatch_count++;
                    end
                    if (day_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, day_if.status);
                        mismatch_count++;
                    end
                end
            end
            if (char_if.valid && char_if.ready) begin
                moved = 1'b1;
                if (parse_date_char(char_if.char_code, char_if.last_char, pred)) begin
                    if (char_stim[chars_checked].typed) pred = char_stim[chars_checked].res;
                    pending_days.push_back(pred);
                end
                chars_checked++;
                chars_taken <= chars_checked;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : rx_drive
        t_rx_mode    mode;
        int unsigned rx_left;
        int unsigned rx_phase;
        bit          held;
        mode     = RX_OPEN;
        rx_left  = 0;
        rx_phase = 0;
        held     = 1'b0;
        day_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && chars_taken >= HOLD_AFTER) begin
                // long back-pressure so the job queue fills and the input stalls
                held = 1'b1;
                day_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (rx_left == 0) begin
                mode    = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            rx_phase++;
            case (mode)
                RX_OPEN:  day_if.ready <= 1'b1;
                RX_LIGHT: day_if.ready <= ($urandom_range(0, 3) != 0);
                RX_COMB:  day_if.ready <= (rx_phase % 5 > 1);
                default:  day_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin : stim_main
        t_dir_row    dir_rows [N_DIR];
        t_char_item  item;
        logic [7:0]  ch;
        int unsigned mon;
        int unsigned dy;
        int unsigned yr;
        int unsigned kind;
        int unsigned n_directed;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned pause_at;

        i_rst_n           <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= 8'h00;
        char_if.last_char <= 1'b0;

        dir_rows = '{
            '{"1/1/1752",   1'b1, 22'd1, 1'b0},  // first day counted
            '{"0/0/1752",   1'b1, 22'd0, 1'b0},  // month zero, day zero
            '{"12311751",   1'b1, 22'd0, 1'b1},  // year before the epoch
            '{"13//1752",   1'b1, 22'd0, 1'b1},  // month above 12
            '{"12319999/x", 1'b0, 22'd0, 1'b0},  // largest year, trailing chars ignored
            '{"1232/1999",  1'b0, 22'd0, 1'b0},  // third month digit opens the day
            '{"#",          1'b1, 22'd0, 1'b1},  // NUL is a stray character
            '{"\377",       1'b1, 22'd0, 1'b1},  // top character code
            '{"5",          1'b1, 22'd0, 1'b1},  // text ends before the year
            '{"3/1/2000",   1'b0, 22'd0, 1'b0}   // day after the leap day of a 400-year
        };

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].text.len(); k++) begin
                ch           = dir_rows[r].text[k];
                item.code    = (ch == CH_NUL_MARK) ? 8'h00 : ch;
                item.is_last = (k == dir_rows[r].text.len() - 1);
                item.typed   = dir_rows[r].typed;
                item.res     = '{day_number: dir_rows[r].day, status: dir_rows[r].status};
                char_stim.push_back(item);
            end
        end
        n_directed = char_stim.size();

        while (char_stim.size() < n_directed + RAND_ITEMS) begin
            date_txt.delete();
            kind = $urandom_range(0, 9);
            if (kind < 9) begin
                mon = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
                dy  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
                case ($urandom_range(0, 7))
                    0:       yr = $urandom_range(1000, 9999);
                    1:       yr = 100 * $urandom_range(18, 99);
                    2:       yr = EPOCH_YEAR - 1 + $urandom_range(0, 1);
                    default: yr = $urandom_range(EPOCH_YEAR, 2400);
                endcase
                put_date_field(mon);
                put_date_field(dy);
                date_txt.push_back(8'(CH_ZERO + yr / 1000));
                date_txt.push_back(8'(CH_ZERO + (yr / 100) % 10));
                date_txt.push_back(8'(CH_ZERO + (yr / 10) % 10));
                if ($urandom_range(0, 9) != 0) date_txt.push_back(8'(CH_ZERO + yr % 10));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) date_txt.push_back(8'($urandom_range(0, 255)));
                if (kind == 8)
                    date_txt[$urandom_range(0, date_txt.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: date_txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        3:       date_txt.push_back(CH_SLASH);
                        default: date_txt.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            foreach (date_txt[k]) begin
                item.code    = date_txt[k];
                item.is_last = (k == date_txt.size() - 1);
                item.typed   = 1'b0;
                item.res     = '{day_number: 22'd0, status: 1'b0};
                char_stim.push_back(item);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pause_at   = n_directed + RAND_ITEMS / 2;
        burst_left = 0;
        foreach (char_stim[i]) begin
            if (i == n_directed || i == pause_at) begin
                // let every outstanding result come back before going on
                char_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_days.size() != 0) @(posedge i_clk);
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    char_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (burst_left != 0) burst_left--;
            char_if.valid     <= 1'b1;
            char_if.char_code <= char_stim[i].code;
            char_if.last_char <= char_stim[i].is_last;
            do @(posedge i_clk); while (!char_if.ready);
        end
        char_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_days.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_days.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
